@@ rtl/oang_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oang_pkg
// Types, constants and helper functions for the octant angle unit.
// ----------------------------------------------------------------------------
package oang_pkg;

    localparam int unsigned CoordW     = 16;
    localparam int unsigned AngleW     = 10;
    localparam int unsigned ScaleShift = 7;   // ratio scale of 128 per octant
    localparam int unsigned OctW       = 3;
    localparam int unsigned DivStages  = 4;
    localparam int unsigned StepsPerStg = CoordW / DivStages;

    // Partial remainder and the dividend/quotient shift word.
    typedef struct packed {
        logic [CoordW-1:0] rem;
        logic [CoordW-1:0] work;
    } t_div;

    // Side information riding along with the divider.
    typedef struct packed {
        logic [OctW-1:0]   oct;
        logic              neg;
        logic              dz;
        logic              undef;
        logic [AngleW-1:0] nlow;
    } t_side;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    function automatic t_div div_step(input t_div d_in, input logic [CoordW-1:0] den);
        logic [CoordW:0] trial;
        logic            qbit;
        t_div            d_out;
        trial = {d_in.rem, d_in.work[CoordW-1]};
        qbit  = (trial >= {1'b0, den});
        if (qbit) begin
            trial = trial - {1'b0, den};
        end
        d_out.rem  = trial[CoordW-1:0];
        d_out.work = {d_in.work[CoordW-2:0], qbit};
        return d_out;
    endfunction

    // Base angle of each octant in eighths of a turn.
    function automatic logic [OctW-1:0] oct_base(input logic [OctW-1:0] oct);
        logic [OctW-1:0] b;
        case (oct)
            3'd0:    b = 3'd1;
            3'd1:    b = 3'd0;
            3'd2:    b = 3'd2;
            3'd3:    b = 3'd3;
            3'd4:    b = 3'd6;
            3'd5:    b = 3'd7;
            3'd6:    b = 3'd5;
            3'd7:    b = 3'd4;
            default: b = 3'd0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

@@ rtl/octant_angle_from_vector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octant_angle_from_vector_unit
// Approximate direction of a 16-bit vector, 1024 units per turn, from a
// linear ratio inside each octant; flags the zero vector as undefined.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle unless the output stalls; nine register stages,
//   the 16-bit divider takes four of them at four quotient bits each.
// Each stage has its own valid bit and takes a new word whenever it is empty
//   or its contents move on, so bubbles collapse under output stalls.
// Reset (synchronous, active low) clears all valid bits; no other state.
// ----------------------------------------------------------------------------
module octant_angle_from_vector_unit
    import oang_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [15:0] vec_x, [31:16] vec_y
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,   // [9:0] angle, [15:10] zero
    output logic             o_m_axis_tuser    // [0] undefined
);

    localparam int unsigned NumStg = 5 + DivStages;
    localparam int unsigned OutStg = NumStg - 1;

    logic [NumStg-1:0] r_vld;
    logic [NumStg:0]   w_rdy;

    // stage 0: input capture
    logic [CoordW-1:0] r_x0, r_y0;
    // stage 1: folded coordinates
    logic [CoordW-1:0] r_ax1, r_ay1, n_ax1, n_ay1;
    logic              r_xo1, r_yo1, r_undef1, n_xo1, n_yo1, n_undef1;
    // stage 2: scaled numerator and divisor
    logic [CoordW-1:0] r_n2, r_den2, n_n2, n_den2;
    logic [OctW-1:0]   r_oct2, n_oct2;
    logic              r_undef2;
    // stage 3: magnitudes
    t_div              r_div3, n_div3;
    logic [CoordW-1:0] r_dmag3, n_dmag3;
    t_side             r_side3, n_side3;
    // divider stages
    t_div              r_div  [DivStages];
    t_div              n_div  [DivStages];
    logic [CoordW-1:0] r_dmag [DivStages];
    t_side             r_side [DivStages];
    // output stage
    logic [AngleW-1:0] r_angle, n_angle;
    logic              r_undef_o;

    // A stage loads when it is empty or its word moves on.
    always_comb begin
        w_rdy[NumStg] = i_m_axis_tready;
        for (int k = NumStg - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NumStg; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: fold into the first quadrant, negation wraps at -32768.
    always_comb begin
        n_xo1    = r_x0[CoordW-1] || (r_x0 == '0);
        n_yo1    = r_y0[CoordW-1] || (r_y0 == '0);
        n_ax1    = n_xo1 ? (CoordW'(0) - r_x0) : r_x0;
        n_ay1    = n_yo1 ? (CoordW'(0) - r_y0) : r_y0;
        n_undef1 = (r_x0 == '0) && (r_y0 == '0);
    end

    // Stage 2: larger coordinate divides smaller one scaled by 128.
    always_comb begin
        logic swap;
        logic [CoordW-1:0] num;
        swap   = $signed(r_ax1) < $signed(r_ay1);
        num    = swap ? r_ax1 : r_ay1;
        n_den2 = swap ? r_ay1 : r_ax1;
        n_n2   = {num[CoordW-1-ScaleShift:0], {ScaleShift{1'b0}}};
        n_oct2 = {r_xo1, r_yo1, swap};
    end

    // Stage 3: signed operands to magnitudes and quotient sign.
    always_comb begin
        n_div3.rem    = '0;
        n_div3.work   = r_n2[CoordW-1] ? (CoordW'(0) - r_n2) : r_n2;
        n_dmag3       = r_den2[CoordW-1] ? (CoordW'(0) - r_den2) : r_den2;
        n_side3.oct   = r_oct2;
        n_side3.neg   = r_n2[CoordW-1] ^ r_den2[CoordW-1];
        n_side3.dz    = (r_den2 == '0);
        n_side3.undef = r_undef2;
        n_side3.nlow  = r_n2[AngleW-1:0];
    end

    // Divider stages, four restoring steps each.
    always_comb begin
        t_div              d;
        logic [CoordW-1:0] den;
        d   = r_div3;
        den = r_dmag3;
        for (int j = 0; j < StepsPerStg; j++) begin
            d = div_step(d, den);
        end
        n_div[0] = d;
        for (int k = 1; k < DivStages; k++) begin
            d   = r_div[k-1];
            den = r_dmag[k-1];
            for (int j = 0; j < StepsPerStg; j++) begin
                d = div_step(d, den);
            end
            n_div[k] = d;
        end
    end

    // Output stage: sign fix, reverse octants with an odd base, add octant base; undefined gives zero.
    always_comb begin
        t_side             s;
        logic [CoordW-1:0] q;
        logic [AngleW-1:0] ratio;
        logic [OctW-1:0]   base;
        s     = r_side[DivStages-1];
        q     = r_div[DivStages-1].work;
        ratio = s.neg ? (AngleW'(0) - q[AngleW-1:0]) : q[AngleW-1:0];
        if (s.dz) begin
            ratio = s.nlow;    // zero divisor passes the scaled value through
        end
        base = oct_base(s.oct);
        if (base[0]) begin
            ratio = AngleW'(1 << ScaleShift) - ratio;
        end
        n_angle = s.undef ? '0 : (ratio + {base, {ScaleShift{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_x0 <= i_s_axis_tdata[CoordW-1:0];
            r_y0 <= i_s_axis_tdata[2*CoordW-1:CoordW];
        end
        if (w_rdy[1]) begin
            r_ax1    <= n_ax1;
            r_ay1    <= n_ay1;
            r_xo1    <= n_xo1;
            r_yo1    <= n_yo1;
            r_undef1 <= n_undef1;
        end
        if (w_rdy[2]) begin
            r_n2     <= n_n2;
            r_den2   <= n_den2;
            r_oct2   <= n_oct2;
            r_undef2 <= r_undef1;
        end
        if (w_rdy[3]) begin
            r_div3  <= n_div3;
            r_dmag3 <= n_dmag3;
            r_side3 <= n_side3;
        end
        if (w_rdy[4]) begin
            r_div[0]  <= n_div[0];
            r_dmag[0] <= r_dmag3;
            r_side[0] <= r_side3;
        end
        for (int k = 1; k < DivStages; k++) begin
            if (w_rdy[4+k]) begin
                r_div[k]  <= n_div[k];
                r_dmag[k] <= r_dmag[k-1];
                r_side[k] <= r_side[k-1];
            end
        end
        if (w_rdy[OutStg]) begin
            r_angle   <= n_angle;
            r_undef_o <= r_side[DivStages-1].undef;
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[OutStg];
    assign o_m_axis_tdata  = {{(16-AngleW){1'b0}}, r_angle};
    assign o_m_axis_tuser  = r_undef_o;

endmodule
`default_nettype wire
